@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/core/sfcp_pkg.sv @@
// Shared constants and types for the servo frame checksum parser.
`timescale 1ns / 1ps
`default_nettype none

package sfcp_pkg;

  localparam int CHANNELS = 14;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 16;
  localparam int POS_W   = 6;
  localparam int CH_IDX_W = 4;
  localparam int STORE_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [POS_W-1:0] FIRST_CH_POS   = POS_W'(2);
  localparam logic [POS_W-1:0] CSUM_LOW_POS   = POS_W'(30);
  localparam logic [POS_W-1:0] FRAME_LAST_POS = POS_W'(31);
  localparam logic [SUM_W-1:0] SUM_MAX        = 16'hFFFF;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'd32;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'd64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BYTE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 1'b0,
    REG_HEADER_SECOND = 1'b1
  } cfg_reg_t;

  // Controller to datapath: load the output register.
  typedef struct packed {
    logic                load;
    logic                ok;
    logic [CH_IDX_W-1:0] idx;
    logic                last;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame_end;   // accepted word closes a frame
    logic frame_good;  // header and checksum matched for that word
    logic at_end_pos;  // next in-frame word would be the final one
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/servo_frame_checksum_parser.sv @@
// Top level of the servo frame checksum parser.
//
//  channel | handshake           | word contents
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_stall | rx_byte, frame_start
//  out     | out_valid/out_stall | frame_ok, channel_index, channel_value,
//          |                     | last_of_frame
//  cfg     | cfg_write           | cfg_index (0 first header, 1 second), cfg_data
//
// At most one input word per cycle; bytes 0..30 of a frame give no result.
// The final byte loads the first result; a good frame sends the other
// CHANNELS-1 one per cycle from the store while out_stall is low; the input stalls meanwhile.
// A rejected frame gives one result. The output register lets later bytes in
// while a result waits; only a word at the final position waits for the slot.
// Synchronous reset: header values to 32 and 64, no frame open, output empty.
`timescale 1ns / 1ps
`default_nettype none

module servo_frame_checksum_parser (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sfcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sfcp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sfcp_pkg::BYTE_W-1:0]      rx_byte,
  input  wire logic                             frame_start,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  frame_ok,
  output logic [sfcp_pkg::CH_IDX_W-1:0]         channel_index,
  output logic [sfcp_pkg::VALUE_W-1:0]          channel_value,
  output logic                                  last_of_frame
);

  sfcp_pkg::ctrl_cmd_t  cmd;
  sfcp_pkg::dp_status_t status;
  logic                 in_accept;

  // A word is taken whenever the controller is not holding the input off.
  assign in_accept = in_valid && !in_stall;

  sfcp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accept     (in_accept),
    .rx_byte       (rx_byte),
    .frame_start   (frame_start),
    .cmd           (cmd),
    .status        (status),
    .frame_ok      (frame_ok),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_of_frame (last_of_frame)
  );

  sfcp_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

endmodule

`default_nettype wire

@@ rtl/core/sfcp_datapath.sv @@
// Datapath: byte position, running sum, header check, channel store, output register.
`timescale 1ns / 1ps
`default_nettype none

module sfcp_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [sfcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sfcp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_accept,
  input  wire logic [sfcp_pkg::BYTE_W-1:0]        rx_byte,
  input  wire logic                               frame_start,
  input  wire sfcp_pkg::ctrl_cmd_t                cmd,
  output sfcp_pkg::dp_status_t                    status,
  output logic                                    frame_ok,
  output logic [sfcp_pkg::CH_IDX_W-1:0]           channel_index,
  output logic [sfcp_pkg::VALUE_W-1:0]            channel_value,
  output logic                                    last_of_frame
);

  logic [sfcp_pkg::BYTE_W-1:0]  header_first;
  logic [sfcp_pkg::BYTE_W-1:0]  header_second;
  logic [sfcp_pkg::POS_W-1:0]   pos;
  logic                         in_frame;
  logic [sfcp_pkg::SUM_W-1:0]   running_sum;
  logic                         header_matched;
  logic [sfcp_pkg::BYTE_W-1:0]  low_hold;
  logic [sfcp_pkg::VALUE_W-1:0] store [sfcp_pkg::CHANNELS];

  logic [sfcp_pkg::POS_W-1:0]   pos_eff;
  logic                         active;
  logic [sfcp_pkg::SUM_W-1:0]   sum_add;
  logic [sfcp_pkg::VALUE_W-1:0] csum;
  logic [sfcp_pkg::SUM_W-1:0]   expect_sum;
  logic [sfcp_pkg::POS_W-1:0]   ch_num;
  logic                         store_we;

  always_comb begin
    pos_eff    = frame_start ? '0 : pos;
    active     = in_accept && (frame_start || in_frame);
    sum_add    = running_sum + sfcp_pkg::SUM_W'(rx_byte);
    csum       = {rx_byte, low_hold};
    expect_sum = sfcp_pkg::SUM_MAX - running_sum;
    ch_num     = (pos_eff - sfcp_pkg::POS_W'(3)) >> 1;
    store_we   = active && pos_eff[0] && (pos_eff > sfcp_pkg::FIRST_CH_POS)
                 && (pos_eff < sfcp_pkg::CSUM_LOW_POS)
                 && (ch_num < sfcp_pkg::POS_W'(sfcp_pkg::CHANNELS));
    status.frame_end  = active && (pos_eff == sfcp_pkg::FRAME_LAST_POS);
    status.frame_good = header_matched && (csum == expect_sum);
    status.at_end_pos = in_frame && (pos == sfcp_pkg::FRAME_LAST_POS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= sfcp_pkg::HEADER_FIRST_RESET;
      header_second <= sfcp_pkg::HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfcp_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        sfcp_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      in_frame       <= 1'b0;
      running_sum    <= '0;
      header_matched <= 1'b0;
      low_hold       <= '0;
    end else if (active) begin
      if (status.frame_end) begin
        in_frame <= 1'b0;
        pos      <= '0;
      end else begin
        in_frame <= 1'b1;
        pos      <= pos_eff + sfcp_pkg::POS_W'(1);
      end
      if (pos_eff == '0) begin
        header_matched <= (rx_byte == header_first);
        running_sum    <= sfcp_pkg::SUM_W'(rx_byte);
      end else if (pos_eff == sfcp_pkg::POS_W'(1)) begin
        header_matched <= header_matched && (rx_byte == header_second);
        running_sum    <= sum_add;
      end else if (pos_eff < sfcp_pkg::CSUM_LOW_POS) begin
        running_sum <= sum_add;
        if (!pos_eff[0]) begin
          low_hold <= rx_byte;
        end
      end else if (pos_eff == sfcp_pkg::CSUM_LOW_POS) begin
        low_hold <= rx_byte;
      end
    end
  end

  // Channel store: written once per channel pair, read by the emit index.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[ch_num[sfcp_pkg::STORE_IDX_W-1:0]] <= {rx_byte, low_hold};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_ok      <= cmd.ok;
      channel_index <= cmd.ok ? cmd.idx : '0;
      channel_value <= cmd.ok ? store[cmd.idx[sfcp_pkg::STORE_IDX_W-1:0]] : '0;
      last_of_frame <= cmd.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sfcp_controller.sv @@
// Controller: result sequencing, output valid and input stall.
`timescale 1ns / 1ps
`default_nettype none

module sfcp_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sfcp_pkg::dp_status_t status,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic                      in_stall,
  output sfcp_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [sfcp_pkg::CH_IDX_W-1:0] idx;
  logic [sfcp_pkg::CH_IDX_W-1:0] idx_next;
  logic                          out_valid_next;
  logic                          slot_free;
  logic                          idx_last;

  always_comb begin
    slot_free      = !out_valid || !out_stall;
    idx_last       = (idx == sfcp_pkg::CH_IDX_W'(sfcp_pkg::CHANNELS - 1));
    in_stall       = (state == ST_EMIT) || (out_valid && out_stall && status.at_end_pos);
    state_next     = state;
    idx_next       = idx;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      ST_RUN: begin
        if (status.frame_end) begin
          cmd.load       = 1'b1;
          cmd.ok         = status.frame_good;
          cmd.idx        = '0;
          cmd.last       = !status.frame_good || (sfcp_pkg::CHANNELS == 1);
          out_valid_next = 1'b1;
          if (status.frame_good && (sfcp_pkg::CHANNELS > 1)) begin
            state_next = ST_EMIT;
            idx_next   = sfcp_pkg::CH_IDX_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load       = 1'b1;
          cmd.ok         = 1'b1;
          cmd.idx        = idx;
          cmd.last       = idx_last;
          out_valid_next = 1'b1;
          if (idx_last) begin
            state_next = ST_RUN;
          end else begin
            idx_next = idx + sfcp_pkg::CH_IDX_W'(1);
          end
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sfcp_checker.sv @@
// Port-level checks for the servo frame checksum parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfcp_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             frame_ok,
  input wire logic [sfcp_pkg::CH_IDX_W-1:0]    channel_index,
  input wire logic [sfcp_pkg::VALUE_W-1:0]     channel_value,
  input wire logic                             last_of_frame
);

  logic [sfcp_pkg::CH_IDX_W+sfcp_pkg::VALUE_W+1:0] out_word;
  logic                                            reject_shape;
  logic                                            top_channel;
  logic                                            mid_burst;
  logic                                            good_step;
  logic [sfcp_pkg::CH_IDX_W-1:0]                   prev_index;

  assign out_word     = {frame_ok, channel_index, channel_value, last_of_frame};
  assign reject_shape = (channel_index == '0) && (channel_value == '0) && last_of_frame;
  assign top_channel  = (channel_index == sfcp_pkg::CH_IDX_W'(sfcp_pkg::CHANNELS - 1));
  assign mid_burst    = out_valid && frame_ok && !last_of_frame;
  assign good_step    = out_valid && frame_ok
                        && (channel_index == prev_index + sfcp_pkg::CH_IDX_W'(1));

  always_ff @(posedge clk) begin
    prev_index <= channel_index;
  end

  // held result stays put
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_word))

  // rejection is a single zeroed word
  `ASSERT_CLK(a_reject_word, clk, rst, out_valid && !frame_ok |-> reject_shape)

  // a good frame ends on the top channel
  `ASSERT_CLK(a_good_last, clk, rst, out_valid && frame_ok && last_of_frame |-> top_channel)

  // channels follow back to back in order
  `ASSERT_CLK(a_good_next, clk, rst, mid_burst && !out_stall |=> good_step)

  // no input word is taken while a channel burst is going out
  `ASSERT_CLK(a_burst_blocks_in, clk, rst, mid_burst && in_valid |-> in_stall)

endmodule

bind servo_frame_checksum_parser sfcp_checker u_checker (.*);

`default_nettype wire
